FILE: hw/rtl/mwsd_pkg.sv
package mwsd_pkg;

    localparam int WINDOW   = 20;
    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 23;

    // window slot index and growth bits of the running sums
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int GROW_W = $clog2(WINDOW);

    // running sum of samples, signed
    localparam int SUM_W   = SAMPLE_W + GROW_W;
    // square of one sample and running sum of squares, unsigned
    localparam int SQ_W    = 2 * SAMPLE_W - 1;
    localparam int SUMSQ_W = SQ_W + GROW_W;
    // radicand and root
    localparam int ROOT_W  = SUM_W;
    localparam int D_W     = 2 * ROOT_W;
    localparam int CNT_W   = $clog2(ROOT_W);

    // reciprocal of the window length, scaled by 2^ROOT_W, rounded down
    localparam logic [ROOT_W-1:0] RECIP = ROOT_W'((64'd1 << ROOT_W) / WINDOW);

    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW - 1);
    localparam logic [ROOT_W-1:0] WIN_ROOT   = ROOT_W'(WINDOW);
    localparam logic [ROOT_W-1:0] OUT_MAX    = ROOT_W'((64'd1 << OUT_W) - 1);
    localparam logic [CNT_W-1:0]  SQRT_LAST  = CNT_W'(ROOT_W - 1);

    typedef struct packed {
        logic load;       // take the new sample into the window
        logic upd1;       // update sum, square the leaving sample
        logic upd2;       // subtract leaving square, square the new sample
        logic upd3;       // add new square
        logic term;       // form window*sumsq and sum^2
        logic diff;       // form radicand, clear root
        logic sqrt_step;  // one root bit
        logic div1;       // reciprocal estimate of root/window
        logic out_load;   // correct, saturate and register result
    } mwsd_cmd_t;

endpackage

FILE: hw/rtl/mwsd_ctrl.sv
module mwsd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output mwsd_pkg::mwsd_cmd_t cmd
);
    import mwsd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UPD1 = 4'd1;
    localparam logic [3:0] S_UPD2 = 4'd2;
    localparam logic [3:0] S_UPD3 = 4'd3;
    localparam logic [3:0] S_TERM = 4'd4;
    localparam logic [3:0] S_DIFF = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_DIV1 = 4'd7;
    localparam logic [3:0] S_DIV2 = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_UPD1;
                end
            end
            S_UPD1:
            begin
                cmd.upd1   = 1'b1;
                state_next = S_UPD2;
            end
            S_UPD2:
            begin
                cmd.upd2   = 1'b1;
                state_next = S_UPD3;
            end
            S_UPD3:
            begin
                cmd.upd3   = 1'b1;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                cnt_next   = SQRT_LAST;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cmd.div1   = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                // hold here while the previous result is still unclaimed
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/mwsd_dp.sv
module mwsd_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mwsd_pkg::mwsd_cmd_t                  cmd,
    input  logic signed [mwsd_pkg::SAMPLE_W-1:0] sample,
    output logic        [mwsd_pkg::OUT_W-1:0]    std_dev
);
    import mwsd_pkg::*;

    logic signed [SAMPLE_W-1:0] win_reg [WINDOW];
    logic [SLOT_W-1:0]          slot_reg;
    logic signed [SAMPLE_W-1:0] new_reg, old_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [SUMSQ_W-1:0]         sumsq_reg;
    logic [D_W-1:0]             ta_reg, tb_reg;
    logic [D_W-1:0]             d_reg;
    logic [ROOT_W+1:0]          rem_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic [ROOT_W-1:0]          qe_reg;
    logic [OUT_W-1:0]           std_dev_reg;

    logic [SAMPLE_W-1:0]        sq_in, sq_mag;
    logic [2*SAMPLE_W-1:0]      sq_full;
    logic [SUM_W-1:0]           sum_mag;
    logic [ROOT_W+3:0]          rem_sh, trial;
    logic [2*ROOT_W-1:0]        recip_prod;
    logic [ROOT_W-1:0]          r_left, q_fix;

    // one shared squarer for the leaving and the entering sample
    assign sq_in   = cmd.upd1 ? old_reg : new_reg;
    assign sq_mag  = sq_in[SAMPLE_W-1] ? (~sq_in + 1'b1) : sq_in;
    assign sq_full = sq_mag * sq_mag;

    assign sum_mag = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    // digit-by-digit square root, one root bit per step
    assign rem_sh = {rem_reg, d_reg[D_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    assign recip_prod = root_reg * RECIP;
    assign r_left     = root_reg - ROOT_W'(qe_reg * WIN_ROOT);
    assign q_fix      = (r_left >= WIN_ROOT) ? qe_reg + 1'b1 : qe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                win_reg[i] <= '0;
            slot_reg  <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                win_reg[slot_reg] <= sample;
                slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
            end
            if (cmd.upd1)
                sum_reg <= sum_reg + SUM_W'(new_reg) - SUM_W'(old_reg);
            if (cmd.upd2)
                sumsq_reg <= sumsq_reg - SUMSQ_W'(sq_reg);
            if (cmd.upd3)
                sumsq_reg <= sumsq_reg + SUMSQ_W'(sq_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            new_reg <= sample;
            old_reg <= win_reg[slot_reg];
        end
        if (cmd.upd1 || cmd.upd2)
            sq_reg <= sq_full[SQ_W-1:0];
        if (cmd.term)
        begin
            ta_reg <= D_W'(sumsq_reg) * D_W'(WINDOW);
            tb_reg <= sum_mag * sum_mag;
        end
        if (cmd.diff)
        begin
            d_reg    <= (ta_reg >= tb_reg) ? ta_reg - tb_reg : '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            d_reg <= {d_reg[D_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= (ROOT_W+2)'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div1)
            qe_reg <= recip_prod[2*ROOT_W-1:ROOT_W];
        if (cmd.out_load)
            std_dev_reg <= (q_fix > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : q_fix[OUT_W-1:0];
    end

    assign std_dev = std_dev_reg;

endmodule

FILE: hw/rtl/moving_window_std_deviation_top.sv
// moving window standard deviation over the last WINDOW samples (Q7.16)
//
// input channel: in_valid / in_ready with the signed 24-bit sample; one
// transfer shifts the sample into the window, replacing the oldest entry
// output channel: out_valid / out_ready with the unsigned 23-bit std_dev,
// the population standard deviation of the window, saturated to 2^23-1
//
// after the input transfer the sequencer runs the running sum update
// (UPD1 to UPD3), forms the radicand (TERM, DIFF), takes the 29 root bits
// of the digit-serial square root, divides by the window length (DIV1,
// DIV2) and raises out_valid; no new sample is taken before that, since
// in_ready is high only while the sequencer is idle
//
// reset clears the window to zeros, which count as samples until pushed out
// a stalled receiver does not block the next input transfer; the finished
// result waits in the output register and the following computation holds
// at its last step until that register is taken
module moving_window_std_deviation_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [mwsd_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [mwsd_pkg::OUT_W-1:0]    std_dev
);
    import mwsd_pkg::*;

    // command bundle from the sequencer to the datapath
    mwsd_cmd_t cmd;

    // sequencer: state, square root step counter, output valid flag
    mwsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: window, running sums, square root and divide
    mwsd_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sample  (sample),
        .std_dev (std_dev)
    );

endmodule
